// ----- design/fdtp_pkg.sv -----
// shared types and constants of the framed decimal token parser
package fdtp_pkg;

	// register reset values
	localparam logic [7:0] START_MARKER_RST = 8'd60;
	localparam logic [7:0] END_MARKER_RST   = 8'd62;
	localparam logic [7:0] MAX_CHARS_RST    = 8'd31;

	// default token capacity of one frame
	localparam int MAX_TOKENS_DEF = 16;

	// queue depths
	localparam int MID_DEPTH = 2;
	localparam int RES_DEPTH = 4;

	// register map, index = paddr[3:2]
	localparam logic [1:0] REG_START_MARKER = 2'd0;
	localparam logic [1:0] REG_END_MARKER   = 2'd1;
	localparam logic [1:0] REG_MAX_CHARS    = 2'd2;

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DIG0  = 8'h30;
	localparam logic [7:0] CH_DIG9  = 8'h39;

	// text byte class
	typedef enum logic [2:0] {
		CLS_ZERO  = 3'd0,
		CLS_SPACE = 3'd1,
		CLS_WS    = 3'd2,
		CLS_PLUS  = 3'd3,
		CLS_MINUS = 3'd4,
		CLS_DIGIT = 3'd5,
		CLS_OTHER = 3'd6
	} char_cls_t;

	// token parse phase
	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_WS   = 4'b0010,
		PH_NUM  = 4'b0100,
		PH_STOP = 4'b1000
	} tok_phase_t;

	// one classified byte handed from front to back
	typedef struct packed {
		logic      is_start;
		logic      is_end;
		char_cls_t cls;
		logic [3:0] digit;
	} byte_item_t;

endpackage

// ----- design/framed_decimal_token_parser.sv -----
// top level: register port, front end, back end and result queue
// path: an accepted byte is registered in the front queue, and its results in the result queue
// throughput: one byte per cycle when nothing stalls; the back end takes a byte whenever the result queue
// has room for two records, and an end marker that closes an open token within capacity writes two records
// in the same cycle, which the consumer drains one beat per cycle
// reset: arst_n clears both queues and all frame state and loads the register defaults
module framed_decimal_token_parser
	import fdtp_pkg::*;
#(
	parameter int MAX_TOKENS = MAX_TOKENS_DEF,
	parameter int TOTAL_W    = $clog2(MAX_TOKENS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         rx_byte,
	output logic               empty,
	input  logic               pop,
	output logic               kind,
	output logic [7:0]         value,
	output logic [TOTAL_W-1:0] token_total,
	output logic               dropped,
	output logic               last,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int REC_W = 11 + TOTAL_W;

	logic [7:0]       start_marker_q;
	logic [7:0]       end_marker_q;
	logic [7:0]       max_chars_q;
	logic             cfg_wr;
	logic [1:0]       reg_idx;

	logic             item_valid;
	byte_item_t       item;
	logic             item_take;
	logic             res_ready;
	logic [1:0]       res_cnt;
	logic [REC_W-1:0] res_rec0;
	logic [REC_W-1:0] res_rec1;
	logic [REC_W-1:0] out_rec;

	// register port
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			end_marker_q   <= END_MARKER_RST;
			max_chars_q    <= MAX_CHARS_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_START_MARKER: start_marker_q <= pwdata[7:0];
				REG_END_MARKER:   end_marker_q   <= pwdata[7:0];
				REG_MAX_CHARS:    max_chars_q    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (reg_idx)
			REG_START_MARKER: prdata = {24'd0, start_marker_q};
			REG_END_MARKER:   prdata = {24'd0, end_marker_q};
			REG_MAX_CHARS:    prdata = {24'd0, max_chars_q};
			default:          prdata = 32'd0;
		endcase
	end

	fdtp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.rx_byte      (rx_byte),
		.start_marker (start_marker_q),
		.end_marker   (end_marker_q),
		.item_valid   (item_valid),
		.item         (item),
		.item_take    (item_take)
	);

	fdtp_back #(
		.MAX_TOKENS (MAX_TOKENS),
		.TOTAL_W    (TOTAL_W),
		.REC_W      (REC_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.max_chars  (max_chars_q),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.res_ready  (res_ready),
		.res_cnt    (res_cnt),
		.res_rec0   (res_rec0),
		.res_rec1   (res_rec1)
	);

	fdtp_rfifo #(
		.W     (REC_W),
		.DEPTH (RES_DEPTH)
	) u_rfifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cnt   (res_cnt),
		.wr_rec0  (res_rec0),
		.wr_rec1  (res_rec1),
		.wr_ready (res_ready),
		.pop      (pop),
		.empty    (empty),
		.rd_rec   (out_rec)
	);

	// unpack the head record
	assign kind        = out_rec[REC_W-1];
	assign value       = out_rec[REC_W-2 -: 8];
	assign token_total = out_rec[TOTAL_W+1:2];
	assign dropped     = out_rec[1];
	assign last        = out_rec[0];

endmodule

// ----- design/fdtp_front.sv -----
// front end: byte classification and the short queue toward the back end
module fdtp_front
	import fdtp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	input  logic [7:0] start_marker,
	input  logic [7:0] end_marker,
	output logic       item_valid,
	output byte_item_t item,
	input  logic       item_take
);

	localparam int PTR_W = (MID_DEPTH > 1) ? $clog2(MID_DEPTH) : 1;
	localparam int CNT_W = $clog2(MID_DEPTH + 1);

	byte_item_t          cls_item;
	byte_item_t          mem_q [MID_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                wr_en;
	logic                rd_en;

	// classify the incoming byte
	always_comb begin
		cls_item.is_start = (rx_byte == start_marker);
		cls_item.is_end   = (rx_byte == end_marker);
		cls_item.digit    = rx_byte[3:0];
		unique case (rx_byte) inside
			CH_NUL:            cls_item.cls = CLS_ZERO;
			CH_SPACE:          cls_item.cls = CLS_SPACE;
			[CH_TAB:CH_CR]:    cls_item.cls = CLS_WS;
			CH_PLUS:           cls_item.cls = CLS_PLUS;
			CH_MINUS:          cls_item.cls = CLS_MINUS;
			[CH_DIG0:CH_DIG9]: cls_item.cls = CLS_DIGIT;
			default:           cls_item.cls = CLS_OTHER;
		endcase
	end

	assign full       = (count_q == CNT_W'(MID_DEPTH));
	assign item_valid = (count_q != '0);
	assign wr_en      = push && !full;
	assign rd_en      = item_take && item_valid;
	assign item       = mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= cls_item;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(MID_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(MID_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/fdtp_back.sv -----
// back end: frame and token state, builds up to two result records per byte
module fdtp_back
	import fdtp_pkg::*;
#(
	parameter int MAX_TOKENS = MAX_TOKENS_DEF,
	parameter int TOTAL_W    = $clog2(MAX_TOKENS + 1),
	parameter int REC_W      = 11 + TOTAL_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       max_chars,
	input  logic             item_valid,
	input  byte_item_t       item,
	output logic             item_take,
	input  logic             res_ready,
	output logic [1:0]       res_cnt,
	output logic [REC_W-1:0] res_rec0,
	output logic [REC_W-1:0] res_rec1
);

	logic               in_frame_q;
	logic [7:0]         char_count_q;
	logic               text_ended_q;
	tok_phase_t         phase_q;
	logic               negative_q;
	logic [7:0]         acc_q;
	logic [TOTAL_W-1:0] seen_q;
	logic               ovf_q;

	logic               nxt_in_frame;
	logic [7:0]         nxt_count;
	logic               nxt_text_ended;
	tok_phase_t         nxt_phase;
	logic               nxt_negative;
	logic [7:0]         nxt_acc;
	logic [TOTAL_W-1:0] nxt_seen;
	logic               nxt_ovf;

	logic [7:0]         e_count;
	logic               e_text_ended;
	tok_phase_t         e_phase;
	logic               e_negative;
	logic [7:0]         e_acc;
	logic [TOTAL_W-1:0] e_seen;
	logic               e_ovf;

	tok_phase_t         work_phase;
	logic               tok_open;
	logic               tok_room;
	logic [7:0]         tok_value;
	logic [7:0]         acc_next;
	logic               emit;
	logic               done;
	logic               lost;
	logic [TOTAL_W-1:0] done_total;
	logic [REC_W-1:0]   tok_rec;
	logic [REC_W-1:0]   done_rec;

	assign item_take = item_valid && res_ready;

	// per-frame values as seen after a possible restart
	always_comb begin
		if (item.is_start) begin
			e_count      = '0;
			e_text_ended = 1'b0;
			e_phase      = PH_IDLE;
			e_negative   = 1'b0;
			e_acc        = '0;
			e_seen       = '0;
			e_ovf        = 1'b0;
		end else begin
			e_count      = char_count_q;
			e_text_ended = text_ended_q;
			e_phase      = phase_q;
			e_negative   = negative_q;
			e_acc        = acc_q;
			e_seen       = seen_q;
			e_ovf        = ovf_q;
		end
	end

	// open token value and capacity check
	assign tok_open  = (e_phase != PH_IDLE);
	assign tok_room  = (e_seen < TOTAL_W'(MAX_TOKENS));
	assign tok_value = e_negative ? (~e_acc + 8'd1) : e_acc;
	assign acc_next  = {e_acc[4:0], 3'b000} + {e_acc[6:0], 1'b0} + {4'b0000, item.digit};

	// next state and result selection
	always_comb begin
		nxt_in_frame   = in_frame_q;
		nxt_count      = e_count;
		nxt_text_ended = e_text_ended;
		nxt_phase      = e_phase;
		nxt_negative   = e_negative;
		nxt_acc        = e_acc;
		nxt_seen       = e_seen;
		nxt_ovf        = e_ovf;
		work_phase     = (e_phase == PH_IDLE) ? PH_WS : e_phase;
		emit           = 1'b0;
		done           = 1'b0;
		lost           = 1'b0;
		done_total     = e_seen;

		if (!in_frame_q) begin
			// outside a frame only the start marker matters
			if (item.is_start) begin
				nxt_in_frame = 1'b1;
			end
		end else if (item.is_end) begin
			// close the open token, then report the frame
			emit         = !e_text_ended && tok_open && tok_room;
			lost         = !e_text_ended && tok_open && !tok_room;
			done         = 1'b1;
			done_total   = e_seen + TOTAL_W'(emit);
			nxt_in_frame = 1'b0;
			nxt_count      = '0;
			nxt_text_ended = 1'b0;
			nxt_phase      = PH_IDLE;
			nxt_negative   = 1'b0;
			nxt_acc        = '0;
			nxt_seen       = '0;
			nxt_ovf        = 1'b0;
		end else if (!item.is_start && !e_text_ended && (e_count < max_chars)) begin
			// text byte inside the kept range
			nxt_count = e_count + 8'd1;
			case (item.cls) inside
				CLS_ZERO, CLS_SPACE: begin
					emit           = tok_open && tok_room;
					lost           = tok_open && !tok_room;
					nxt_text_ended = (item.cls == CLS_ZERO);
					nxt_seen       = e_seen + TOTAL_W'(emit);
					nxt_ovf        = e_ovf || lost;
					nxt_phase      = PH_IDLE;
					nxt_negative   = 1'b0;
					nxt_acc        = '0;
				end
				default: begin
					unique case (work_phase)
						PH_WS: begin
							if (item.cls == CLS_WS) begin
								nxt_phase = PH_WS;
							end else if (item.cls == CLS_PLUS || item.cls == CLS_MINUS) begin
								nxt_negative = (item.cls == CLS_MINUS);
								nxt_phase    = PH_NUM;
							end else if (item.cls == CLS_DIGIT) begin
								nxt_acc   = acc_next;
								nxt_phase = PH_NUM;
							end else begin
								nxt_phase = PH_STOP;
							end
						end
						PH_NUM: begin
							if (item.cls == CLS_DIGIT) begin
								nxt_acc = acc_next;
							end else begin
								nxt_phase = PH_STOP;
							end
						end
						PH_STOP: nxt_phase = PH_STOP;
						default: nxt_phase = work_phase;
					endcase
				end
			endcase
		end
	end

	// result records: {kind, value, token_total, dropped, last}
	assign tok_rec  = {1'b0, tok_value, {TOTAL_W{1'b0}}, 1'b0, 1'b0};
	assign done_rec = {1'b1, 8'd0, done_total, e_ovf || lost, 1'b1};
	assign res_cnt  = item_take ? ({1'b0, emit} + {1'b0, done}) : 2'd0;
	assign res_rec0 = emit ? tok_rec : done_rec;
	assign res_rec1 = done_rec;

	// state registers, updated when a byte is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			char_count_q <= '0;
			text_ended_q <= 1'b0;
			phase_q      <= PH_IDLE;
			negative_q   <= 1'b0;
			acc_q        <= '0;
			seen_q       <= '0;
			ovf_q        <= 1'b0;
		end else if (item_take) begin
			in_frame_q   <= nxt_in_frame;
			char_count_q <= nxt_count;
			text_ended_q <= nxt_text_ended;
			phase_q      <= nxt_phase;
			negative_q   <= nxt_negative;
			acc_q        <= nxt_acc;
			seen_q       <= nxt_seen;
			ovf_q        <= nxt_ovf;
		end
	end

endmodule

// ----- design/fdtp_rfifo.sv -----
// result queue, takes up to two records per cycle and hands out one
module fdtp_rfifo
	import fdtp_pkg::*;
#(
	parameter int W     = 16,
	parameter int DEPTH = RES_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [1:0]   wr_cnt,
	input  logic [W-1:0] wr_rec0,
	input  logic [W-1:0] wr_rec1,
	output logic         wr_ready,
	input  logic         pop,
	output logic         empty,
	output logic [W-1:0] rd_rec
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] wr_ptr_p1;
	logic             rd_en;

	assign wr_ready  = (count_q <= CNT_W'(DEPTH - 2));
	assign empty     = (count_q == '0);
	assign rd_en     = pop && !empty;
	assign rd_rec    = mem_q[rd_ptr_q];
	assign wr_ptr_p1 = wr_ptr_q + 1'b1;

	// storage, second record goes to the following slot
	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= wr_rec0;
		end
		if (wr_cnt == 2'd2) begin
			mem_q[wr_ptr_p1] <= wr_rec1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(wr_cnt);
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(wr_cnt) - CNT_W'(rd_en);
		end
	end

endmodule

// ----- design/fdtp_checker.sv -----
// port-level checker of the framed decimal token parser and its bind
module fdtp_checker
	import fdtp_pkg::*;
#(
	parameter int MAX_TOKENS = MAX_TOKENS_DEF,
	parameter int TOTAL_W    = $clog2(MAX_TOKENS + 1)
) (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic               kind,
	input logic [7:0]         value,
	input logic [TOTAL_W-1:0] token_total,
	input logic               dropped,
	input logic               last
);

	// result queue is empty while reset is held
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result queue not empty in reset");

	// a waiting beat that is not taken stays unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(kind) && $stable(value)
			&& $stable(token_total) && $stable(dropped) && $stable(last)))
		else $error("waiting result beat changed");

	// frame done and last travel together
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (kind == last))
		else $error("last does not match kind");

	// token beats carry no frame summary
	a_token_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !kind) |-> (token_total == '0 && !dropped))
		else $error("token beat with frame summary");

	// frame done beat has zero value and a count within capacity
	a_done_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind) |-> (value == 8'd0 && token_total <= TOTAL_W'(MAX_TOKENS)))
		else $error("bad frame done beat");

endmodule

bind framed_decimal_token_parser fdtp_checker #(
	.MAX_TOKENS (MAX_TOKENS),
	.TOTAL_W    (TOTAL_W)
) u_fdtp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.kind        (kind),
	.value       (value),
	.token_total (token_total),
	.dropped     (dropped),
	.last        (last)
);

// ----- verif/tb_framed_decimal_token_parser.sv -----
// testbench for the framed decimal token parser: directed and random frames checked against a predictor
`timescale 1ns / 100ps

module tb_framed_decimal_token_parser;
	import fdtp_pkg::*;

	// one expected output beat
	typedef struct packed {
		logic       kind;
		logic [7:0] value;
		logic [4:0] total;
		logic       dropped;
		logic       last;
	} parse_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push = 1'b0;
	logic [7:0]  rx_byte = 8'd0;
	logic        pop = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'd0;
	logic [31:0] pwdata = 32'd0;
	wire         full;
	wire         empty;
	wire         kind;
	wire  [7:0]  value;
	wire  [4:0]  token_total;
	wire         dropped;
	wire         last;
	wire  [31:0] prdata;
	wire         pready;

	framed_decimal_token_parser dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .rx_byte(rx_byte),
		.empty(empty), .pop(pop),
		.kind(kind), .value(value), .token_total(token_total),
		.dropped(dropped), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// bytes waiting to be sent and results waiting to arrive
	logic [7:0]    byte_backlog[$];
	parse_result_t expected_results[$];

	int idle_pct = 37;
	int bytes_queued = 0;
	int bytes_accepted = 0;
	int tokens_checked = 0;
	int frames_checked = 0;
	int dropped_frames = 0;
	int mismatches = 0;

	// register copies
	logic [7:0] marker_start = START_MARKER_RST;
	logic [7:0] marker_end   = END_MARKER_RST;
	logic [7:0] text_limit   = MAX_CHARS_RST;

	// frame and token state of the predictor
	logic       in_frame = 1'b0;
	logic [7:0] text_len = 8'd0;
	logic       text_done = 1'b0;
	tok_phase_t tok_phase = PH_IDLE;
	logic       tok_negative = 1'b0;
	logic [7:0] tok_acc = 8'd0;
	logic [4:0] tok_count = 5'd0;
	logic       tok_overflow = 1'b0;

	initial forever #6 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic void clear_frame();
		text_len = 8'd0;
		text_done = 1'b0;
		tok_phase = PH_IDLE;
		tok_negative = 1'b0;
		tok_acc = 8'd0;
		tok_count = 5'd0;
		tok_overflow = 1'b0;
	endfunction

	// emit the open token unless the frame is at capacity
	function automatic void close_token();
		logic [7:0] v;
		if (tok_phase != PH_IDLE) begin
			v = tok_negative ? 8'd0 - tok_acc : tok_acc;
			if (tok_count < MAX_TOKENS_DEF) begin
				expected_results.push_back('{1'b0, v, 5'd0, 1'b0, 1'b0});
				tok_count++;
			end else begin
				tok_overflow = 1'b1;
			end
		end
		tok_phase = PH_IDLE;
		tok_negative = 1'b0;
		tok_acc = 8'd0;
	endfunction

	function automatic void take_text_byte(logic [7:0] c);
		logic is_digit;
		is_digit = (c >= CH_DIG0) && (c <= CH_DIG9);
		if (text_done || text_len >= text_limit)
			return;
		text_len++;
		if (c == CH_NUL) begin
			text_done = 1'b1;
			close_token();
			return;
		end
		if (c == CH_SPACE) begin
			close_token();
			return;
		end
		if (tok_phase == PH_IDLE)
			tok_phase = PH_WS;
		// atoi style: whitespace, then one sign, then digits until anything else
		if (tok_phase == PH_WS) begin
			if (c >= CH_TAB && c <= CH_CR) begin
				tok_phase = PH_WS;
			end else if (c == CH_MINUS || c == CH_PLUS) begin
				tok_negative = (c == CH_MINUS);
				tok_phase = PH_NUM;
			end else if (is_digit) begin
				tok_acc = tok_acc * 8'd10 + (c - CH_DIG0);
				tok_phase = PH_NUM;
			end else begin
				tok_phase = PH_STOP;
			end
		end else if (tok_phase == PH_NUM) begin
			if (is_digit)
				tok_acc = tok_acc * 8'd10 + (c - CH_DIG0);
			else
				tok_phase = PH_STOP;
		end
	endfunction

	function automatic void predict_byte(logic [7:0] c);
		if (!in_frame) begin
			if (c == marker_start) begin
				in_frame = 1'b1;
				clear_frame();
			end
			return;
		end
		// a start marker inside a frame restarts it; with equal markers it also closes
		if (c == marker_start)
			clear_frame();
		if (c == marker_end) begin
			if (!text_done)
				close_token();
			expected_results.push_back('{1'b1, 8'd0, tok_count, tok_overflow, 1'b1});
			in_frame = 1'b0;
			clear_frame();
			return;
		end
		if (c == marker_start)
			return;
		take_text_byte(c);
	endfunction

	// ---------------------------------------------------------------- driver and monitor

	// input side: hold the beat while full, otherwise send or idle at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				predict_byte(rx_byte);
				bytes_accepted++;
			end
			if (!push || !full) begin
				if (byte_backlog.size() != 0 && int'($urandom_range(99)) >= idle_pct) begin
					push <= 1'b1;
					rx_byte <= byte_backlog.pop_front();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endfunction

	// output side: check each accepted beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result beat kind %0d value %0d", $time, kind, value);
				end else begin
					parse_result_t exp_r;
					exp_r = expected_results.pop_front();
					check_field("kind", 8'(exp_r.kind), 8'(kind));
					check_field("value", exp_r.value, value);
					check_field("token_total", 8'(exp_r.total), 8'(token_total));
					check_field("dropped", 8'(exp_r.dropped), 8'(dropped));
					check_field("last", 8'(exp_r.last), 8'(last));
					if (exp_r.last) begin
						frames_checked++;
						if (exp_r.dropped)
							dropped_frames++;
					end else begin
						tokens_checked++;
					end
				end
			end
			pop <= (int'($urandom_range(99)) >= idle_pct);
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic void add_byte(logic [7:0] c);
		byte_backlog.push_back(c);
		bytes_queued++;
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endfunction

	// whitespace, sign and digits with the odd junk byte
	function automatic void add_token();
		int digits;
		if ($urandom_range(99) < 20)
			add_byte(CH_TAB + 8'($urandom_range(4)));
		if ($urandom_range(99) < 30)
			add_byte($urandom_range(1) ? CH_MINUS : CH_PLUS);
		digits = $urandom_range(4);
		for (int i = 0; i < digits; i++)
			add_byte(CH_DIG0 + 8'($urandom_range(9)));
		if ($urandom_range(99) < 8)
			add_byte(8'($urandom_range(255)));
	endfunction

	// mostly well-formed frames, some noise and broken ones
	function automatic void add_frame(int max_tok);
		int n;
		if ($urandom_range(99) < 12) begin
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(99) < 30)
					add_byte($urandom_range(1) ? marker_start : marker_end);
				else
					add_byte(8'($urandom_range(255)));
			end
			return;
		end
		if ($urandom_range(99) < 10)
			add_byte(8'($urandom_range(255)));
		add_byte(marker_start);
		n = $urandom_range(max_tok);
		for (int i = 0; i < n; i++) begin
			add_token();
			if ($urandom_range(99) < 3)
				add_byte(marker_start);
			if (i == n - 1 && $urandom_range(1))
				continue;
			if ($urandom_range(99) < 4)
				add_byte(CH_NUL);
			else
				add_byte(CH_SPACE);
			if ($urandom_range(99) < 10)
				add_byte(CH_SPACE);
		end
		if ($urandom_range(99) < 93)
			add_byte(marker_end);
	endfunction

	// sender stops until every expected beat has arrived and the pipe is quiet
	task automatic wait_drained();
		do @(negedge clk);
		while (byte_backlog.size() != 0 || push || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_frames(int upto, int max_tok);
		while (bytes_queued < upto)
			add_frame(max_tok);
		wait_drained();
	endtask

	task automatic reg_write(logic [1:0] idx, logic [7:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, data};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_START_MARKER: marker_start = data;
			REG_END_MARKER:   marker_end = data;
			REG_MAX_CHARS:    text_limit = data;
			default: ;
		endcase
	endtask

	task automatic set_config(logic [7:0] s, logic [7:0] e, logic [7:0] m);
		reg_write(REG_START_MARKER, s);
		reg_write(REG_END_MARKER, e);
		reg_write(REG_MAX_CHARS, m);
		@(negedge clk);
	endtask

	initial begin
		logic [7:0] s, e, m;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: ignored bytes, whitespace, signs, wraparound, junk, restart,
		// zero byte, and an open token closed by the end marker
		add_byte(8'hFF);
		add_byte(CH_NUL);
		add_text("<\t-12 +259 x <9 >");
		add_text("<42");
		add_byte(CH_NUL);
		add_text("5>");
		add_text("<->");
		wait_drained();

		// default registers
		run_frames(350, 6);

		// long text so frames overflow the token capacity, no idling
		idle_pct = 0;
		set_config(START_MARKER_RST, END_MARKER_RST, 8'd255);
		run_frames(700, 20);
		idle_pct = 37;

		// register extremes
		set_config(8'h00, 8'hFF, 8'd1);
		run_frames(850, 4);
		set_config(8'hFF, 8'h00, 8'd255);
		run_frames(1000, 20);

		// equal markers
		set_config(8'h23, 8'h23, MAX_CHARS_RST);
		run_frames(1150, 6);

		// random settings
		for (int k = 0; k < 4; k++) begin
			s = 8'($urandom_range(255));
			e = ($urandom_range(3) == 0) ? s : 8'($urandom_range(255));
			m = $urandom_range(1) ? 8'($urandom_range(1, 40)) : 8'($urandom_range(1, 255));
			set_config(s, e, m);
			run_frames(1150 + 200 * (k + 1), 8);
		end

		repeat (8) @(negedge clk);
		$display("run covered %0d bytes under 9 register settings", bytes_accepted);
		$display("checked %0d token values and %0d frame ends, %0d with dropped tokens",
			tokens_checked, frames_checked, dropped_frames);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("** framed_decimal_token_parser: PASSED **");
		end else begin
			$display("** framed_decimal_token_parser: FAILED **");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", expected_results.size());
		$display("** framed_decimal_token_parser: FAILED **");
		$finish;
	end

endmodule

// ----- files.f -----
design/fdtp_pkg.sv
design/fdtp_front.sv
design/fdtp_back.sv
design/fdtp_rfifo.sv
design/framed_decimal_token_parser.sv
design/fdtp_checker.sv
verif/tb_framed_decimal_token_parser.sv
